>>> rtl/core/cwr_pkg.sv
// Shared types and constants for the text console character writer.
package cwr_pkg;

    // Input action codes
    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CLEAR
    } state_t;

    // Cursor update commands
    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_ADVANCE,
        CUR_NEWLINE,
        CUR_HOME
    } cursor_op_t;

    // Cursor position flags seen by the sequencer
    typedef struct packed {
        logic last_col;
        logic last_row;
    } cursor_status_t;

    localparam logic [7:0] BLANK_CHAR = 8'h20;
    localparam logic [7:0] LINE_FEED  = 8'h0A;
    localparam logic [7:0] NUL_CHAR   = 8'h00;

endpackage

>>> rtl/core/cwr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cwr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/cwr_cursor.sv
// Cursor column, row and linear cell position with a shared row base adder.
module cwr_cursor
    import cwr_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cursor_op_t                          op,
    output logic [$clog2(COLUMNS)-1:0]          col,
    output logic [$clog2(ROWS)-1:0]             row,
    output logic [$clog2(COLUMNS*ROWS)-1:0]     pos,
    output cursor_status_t                      status
);

    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);
    localparam int AW = $clog2(COLUMNS * ROWS);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] base_reg, base_next;
    logic [AW-1:0] base_step;

    // Start of the following row
    assign base_step = base_reg + AW'(COLUMNS);

    // Flag the edges of the screen
    assign status.last_col = (col_reg == CW'(COLUMNS - 1));
    assign status.last_row = (row_reg == RW'(ROWS - 1));

    // Next cursor position
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        pos_next  = pos_reg;
        base_next = base_reg;
        case (op)
            CUR_HOLD:
            begin
            end
            CUR_ADVANCE:
            begin
                pos_next = pos_reg + 1'b1;
                if (status.last_col)
                begin
                    col_next  = '0;
                    row_next  = row_reg + 1'b1;
                    base_next = base_step;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            CUR_NEWLINE:
            begin
                col_next  = '0;
                row_next  = row_reg + 1'b1;
                base_next = base_step;
                pos_next  = base_step;
            end
            CUR_HOME:
            begin
                col_next  = '0;
                row_next  = '0;
                base_next = '0;
                pos_next  = '0;
            end
            default:
            begin
            end
        endcase
    end

    // Hold the cursor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            pos_reg  <= '0;
            base_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            pos_reg  <= pos_next;
            base_reg <= base_next;
        end
    end

    assign col = col_reg;
    assign row = row_reg;
    assign pos = pos_reg;

endmodule

>>> rtl/core/text_console_char_writer_unit.sv
// Text console character writer: sequencer, character store and result beat.
//
//  Channel  | Signals                                   | Handshake
//  ---------+-------------------------------------------+---------------------------
//  command  | action, char_code, cell_address          | taken when start & !busy
//  result   | cursor_col, cursor_row, cell_char,        | one-cycle beat on done
//           | screen_cleared                            |
//
// Put, zero char, unused action and out-of-range read: result beat in the cycle after start.
// Read in range: the beat waits on the registered read port of the character RAM, then on the result registers.
// Clear, or a put that runs off the last row: the sweep counter writes one cell per
// cycle through the single RAM write port, then the beat is given.
// After reset the same sweep blanks the store; busy is high and no result beat is
// given for it. The receiver cannot stall results.
module text_console_char_writer_unit
    import cwr_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [7:0]  char_code,
    input  logic [10:0] cell_address,
    output logic        done,
    output logic [6:0]  cursor_col,
    output logic [4:0]  cursor_row,
    output logic [7:0]  cell_char,
    output logic        screen_cleared
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = $clog2(CELLS);

    state_t         state_reg, state_next;
    logic [AW-1:0]  sweep_reg, sweep_next;
    logic           report_reg, report_next;
    logic           done_reg, done_next;
    logic [7:0]     cell_reg, cell_next;
    logic           cleared_reg, cleared_next;

    logic           accept;
    logic           addr_ok;
    cursor_op_t     cur_op;
    cursor_status_t cur_status;
    logic [CW-1:0]  col;
    logic [RW-1:0]  row;
    logic [AW-1:0]  pos;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [7:0]     ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [7:0]     ram_rdata;

    cwr_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (cur_op),
        .col    (col),
        .row    (row),
        .pos    (pos),
        .status (cur_status)
    );

    cwr_ram #(
        .WIDTH (8),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign addr_ok = (32'(cell_address) < 32'(CELLS));

    // Next state, RAM access and result beat
    always_comb
    begin
        state_next   = state_reg;
        sweep_next   = sweep_reg;
        report_next  = report_reg;
        done_next    = 1'b0;
        cell_next    = cell_reg;
        cleared_next = cleared_reg;
        cur_op       = CUR_HOLD;
        ram_we       = 1'b0;
        ram_waddr    = pos;
        ram_wdata    = char_code;
        ram_raddr    = AW'(cell_address);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // default to a plain beat next cycle
                    done_next    = 1'b1;
                    cell_next    = NUL_CHAR;
                    cleared_next = 1'b0;
                    case (action_t'(action))
                        ACT_PUT:
                        begin
                            if (char_code == LINE_FEED)
                            begin
                                if (cur_status.last_row)
                                begin
                                    cur_op      = CUR_HOME;
                                    done_next   = 1'b0;
                                    state_next  = ST_CLEAR;
                                    sweep_next  = '0;
                                    report_next = 1'b1;
                                end
                                else
                                begin
                                    cur_op = CUR_NEWLINE;
                                end
                            end
                            else if (char_code != NUL_CHAR)
                            begin
                                ram_we = 1'b1;
                                if (cur_status.last_col && cur_status.last_row)
                                begin
                                    cur_op      = CUR_HOME;
                                    done_next   = 1'b0;
                                    state_next  = ST_CLEAR;
                                    sweep_next  = '0;
                                    report_next = 1'b1;
                                end
                                else
                                begin
                                    cur_op = CUR_ADVANCE;
                                end
                            end
                        end
                        ACT_CLEAR:
                        begin
                            cur_op      = CUR_HOME;
                            done_next   = 1'b0;
                            state_next  = ST_CLEAR;
                            sweep_next  = '0;
                            report_next = 1'b1;
                        end
                        ACT_READ:
                        begin
                            if (addr_ok)
                            begin
                                done_next  = 1'b0;
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // read data from the registered RAM port for the address given in ST_IDLE is valid here
                done_next    = 1'b1;
                cell_next    = ram_rdata;
                cleared_next = 1'b0;
                state_next   = ST_IDLE;
            end
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg;
                ram_wdata = BLANK_CHAR;
                if (sweep_reg == AW'(CELLS - 1))
                begin
                    state_next   = ST_IDLE;
                    done_next    = report_reg;
                    cell_next    = NUL_CHAR;
                    cleared_next = 1'b1;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state; reset starts the blanking sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            sweep_reg  <= '0;
            report_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sweep_reg  <= sweep_next;
            report_reg <= report_next;
            done_reg   <= done_next;
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        cell_reg    <= cell_next;
        cleared_reg <= cleared_next;
    end

    assign done           = done_reg;
    assign cursor_col     = 7'(col);
    assign cursor_row     = 5'(row);
    assign cell_char      = cell_reg;
    assign screen_cleared = cleared_reg;

    // A blanking beat always reports the home position
    a_clear_homes: assert property (@(posedge clk) disable iff (!rst_n)
        (done && screen_cleared) |-> (cursor_col == 7'd0 && cursor_row == 5'd0))
        else $error("cleared beat without home cursor");

    // A read always finishes with a beat the next cycle
    a_read_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (done && !screen_cleared))
        else $error("read did not produce a beat");

    // The sweep never leaves the store
    a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (32'(sweep_reg) < 32'(CELLS)))
        else $error("sweep address out of range");

    // No beat carries both a character and a blank screen
    a_beat_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cell_char == NUL_CHAR || !screen_cleared))
        else $error("beat mixes read data and clear");

endmodule
